// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/i2cm_pkg.sv
// Types and constants of the I2C master bit engine.
`timescale 1ns / 1ps
package i2cm_pkg;

    // Command codes, equal to the opcode field values
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int PHASE_W = 5;
    localparam int SUB_W   = 2;

    // Tick indexes inside each command
    localparam logic [PHASE_W-1:0] START_SDA_LOW  = 5'd1;
    localparam logic [PHASE_W-1:0] STOP_SCL_HIGH  = 5'd1;
    localparam logic [PHASE_W-1:0] STOP_SDA_HIGH  = 5'd2;
    localparam logic [PHASE_W-1:0] WR_BITS_END    = 5'd24;
    localparam logic [PHASE_W-1:0] WR_ACK_SCL     = 5'd25;
    localparam logic [PHASE_W-1:0] WR_LAST        = 5'd26;
    localparam logic [PHASE_W-1:0] RD_BITS_END    = 5'd16;
    localparam logic [PHASE_W-1:0] RD_ACK_SCL     = 5'd17;
    localparam logic [PHASE_W-1:0] RD_ACK_LOW     = 5'd18;

    // Position inside one written bit slot
    localparam logic [SUB_W-1:0] SUB_DATA = 2'd0;
    localparam logic [SUB_W-1:0] SUB_HIGH = 2'd1;
    localparam logic [SUB_W-1:0] SUB_LAST = 2'd2;

    // One classified tick request
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_sample;
    } tick_req_t;

    // One result
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
    } result_t;

endpackage

// File: rtl/i2cm_ifs.sv
// Valid/ready channel interfaces for tick requests and results.
`timescale 1ns / 1ps
interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;

    modport source (output valid, opcode, write_data, send_ack, sda_sample, input ready);
    modport sink   (input valid, opcode, write_data, send_ack, sda_sample, output ready);
endinterface

interface i2cm_result_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    read_data, ack_seen, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    read_data, ack_seen, output ready);
endinterface

// File: rtl/i2cm_front.sv
// Front end: accepts tick requests and classifies the opcode.
`timescale 1ns / 1ps
module i2cm_front import i2cm_pkg::*;
(
    i2cm_tick_if.sink tick,
    output logic      push_valid,
    input  logic      push_ready,
    output tick_req_t push_req
);

    cmd_t cmd;

    // Opcodes outside the command set count as no command
    always_comb
    begin
        case (tick.opcode)
            3'(CMD_START): cmd = CMD_START;
            3'(CMD_STOP):  cmd = CMD_STOP;
            3'(CMD_WRITE): cmd = CMD_WRITE;
            3'(CMD_READ):  cmd = CMD_READ;
            default:       cmd = CMD_NONE;
        endcase
    end

    assign push_valid          = tick.valid;
    assign tick.ready          = push_ready;
    assign push_req.cmd        = cmd;
    assign push_req.write_data = tick.write_data;
    assign push_req.send_ack   = tick.send_ack;
    assign push_req.sda_sample = tick.sda_sample;

endmodule

// File: rtl/i2cm_queue.sv
// Short request queue between the front end and the sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i2cm_queue import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  tick_req_t push_req,
    output logic      pop_valid,
    input  logic      pop,
    output tick_req_t pop_req
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    tick_req_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_req    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_push_only_grows, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `ASSERT_IMPL(a_ptrs_meet_when_empty, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

// File: rtl/i2cm_back.sv
// Back end: pin sequencer that steps one tick per request, with result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i2cm_back import i2cm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  tick_req_t req,
    output logic      pop,
    output logic      res_valid,
    input  logic      res_ready,
    output result_t   res
);

    cmd_t               cmd_reg, cmd_next, cmd_w;
    logic [PHASE_W-1:0] phase_reg, phase_next, k;
    logic [SUB_W-1:0]   sub_reg, sub_next;
    logic [7:0]         shift_reg, shift_next;
    logic               ack_choice_reg, ack_choice_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               sda_en_reg, sda_en_next;
    logic               ack_flag_reg, ack_flag_next;
    logic [7:0]         read_hold_reg, read_hold_next;
    logic               done;
    logic               res_valid_reg;
    result_t            res_reg;

    // Step when a request waits and the result slot is free or draining
    assign pop       = req_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Sequencer next state
    always_comb
    begin
        cmd_w           = cmd_reg;
        k               = phase_reg;
        sub_next        = sub_reg;
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_en_next     = sda_en_reg;
        ack_flag_next   = ack_flag_reg;
        read_hold_next  = read_hold_reg;
        done            = 1'b0;

        // Launch a new command only when idle; ignore it otherwise
        if (cmd_reg == CMD_NONE)
        begin
            if (req.cmd != CMD_NONE)
            begin
                cmd_w    = req.cmd;
                k        = '0;
                sub_next = SUB_DATA;
                if (req.cmd == CMD_WRITE)
                begin
                    shift_next = req.write_data;
                end
                if (req.cmd == CMD_READ)
                begin
                    shift_next      = '0;
                    ack_choice_next = req.send_ack;
                end
            end
        end
        else
        begin
            k        = phase_reg + 1'b1;
            sub_next = (sub_reg == SUB_LAST) ? SUB_DATA : sub_reg + 1'b1;
        end

        case (cmd_w)
            CMD_START:
            begin
                if (k == '0)
                begin
                    sda_en_next = 1'b1;
                    sda_next    = 1'b1;
                    scl_next    = 1'b1;
                end
                else if (k == START_SDA_LOW)
                begin
                    sda_next = 1'b0;
                end
                else
                begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
            end
            CMD_STOP:
            begin
                if (k == '0)
                begin
                    sda_en_next = 1'b1;
                    scl_next    = 1'b0;
                    sda_next    = 1'b0;
                end
                else if (k == STOP_SCL_HIGH)
                begin
                    scl_next = 1'b1;
                end
                else if (k == STOP_SDA_HIGH)
                begin
                    sda_next = 1'b1;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                if (k < WR_BITS_END)
                begin
                    // Three ticks per bit: data, clock high, clock low
                    if (sub_next == SUB_DATA)
                    begin
                        sda_en_next = 1'b1;
                        sda_next    = shift_next[7];
                        shift_next  = {shift_next[6:0], 1'b0};
                    end
                    else if (sub_next == SUB_HIGH)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                else if (k == WR_BITS_END)
                begin
                    sda_next    = 1'b1;
                    sda_en_next = 1'b0;
                end
                else if (k == WR_ACK_SCL)
                begin
                    scl_next = 1'b1;
                end
                else
                begin
                    ack_flag_next = req.sda_sample;
                    scl_next      = 1'b0;
                    done          = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (k < RD_BITS_END)
                begin
                    if (!k[0])
                    begin
                        sda_next    = 1'b1;
                        sda_en_next = 1'b0;
                        scl_next    = 1'b1;
                    end
                    else
                    begin
                        shift_next = {shift_next[6:0], req.sda_sample};
                        scl_next   = 1'b0;
                    end
                end
                else if (k == RD_BITS_END)
                begin
                    sda_en_next = 1'b1;
                    sda_next    = !ack_choice_next;
                end
                else if (k == RD_ACK_SCL)
                begin
                    scl_next = 1'b1;
                end
                else if (k == RD_ACK_LOW)
                begin
                    scl_next = 1'b0;
                end
                else
                begin
                    read_hold_next = shift_next;
                    done           = 1'b1;
                end
            end
            default:
            begin
                cmd_w = CMD_NONE;
            end
        endcase

        if (done)
        begin
            cmd_next   = CMD_NONE;
            phase_next = '0;
        end
        else
        begin
            cmd_next   = cmd_w;
            phase_next = k;
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= CMD_NONE;
            phase_reg      <= '0;
            sub_reg        <= SUB_DATA;
            shift_reg      <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            sda_en_reg     <= 1'b1;
            ack_flag_reg   <= 1'b0;
            read_hold_reg  <= '0;
        end
        else if (pop)
        begin
            cmd_reg        <= cmd_next;
            phase_reg      <= phase_next;
            sub_reg        <= sub_next;
            shift_reg      <= shift_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            sda_en_reg     <= sda_en_next;
            ack_flag_reg   <= ack_flag_next;
            read_hold_reg  <= read_hold_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg.scl_level <= scl_next;
            res_reg.sda_level <= sda_next;
            res_reg.sda_drive <= sda_en_next;
            res_reg.busy_res  <= (cmd_next != CMD_NONE);
            res_reg.done_res  <= done;
            res_reg.read_data <= read_hold_next;
            res_reg.ack_seen  <= ack_flag_next;
        end
    end

    `ASSERT_IMPL(a_idle_phase_zero, clk, rst_n, cmd_reg == CMD_NONE, phase_reg == '0)
    `ASSERT_IMPL(a_write_phase_bound, clk, rst_n, cmd_reg == CMD_WRITE, phase_reg < WR_LAST)
    `ASSERT_NEXT(a_busy_ignores_cmd, clk, rst_n, pop && cmd_reg != CMD_NONE, cmd_reg == $past(cmd_reg) || cmd_reg == CMD_NONE)
    `ASSERT_IMPL(a_done_not_busy, clk, rst_n, res_valid_reg && res_reg.done_res, !res_reg.busy_res)

endmodule

// File: rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine.
`timescale 1ns / 1ps
// Tick-driven I2C master pin sequencer. Every request on the tick channel is one bus
// timing tick and yields exactly one result: the SCL level, SDA level and SDA drive
// enable after that tick, plus busy/done, the last read byte and the last ACK sample.
// A command (start, stop, write byte, read byte) is taken only on a tick that finds the
// sequencer idle; commands on busy ticks are dropped. Start takes 3 ticks, stop 4, write
// byte 27 and read byte 20. One tick is accepted per clock cycle as long as results are
// taken; a request passes the queue entry and then the result register.
// A queue of QUEUE_DEPTH requests sits between the opcode decoder and the sequencer, so
// the tick channel keeps accepting while a finished result waits on the result channel.
module i2c_master_bit_engine import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    i2cm_tick_if.sink    tick,
    i2cm_result_if.source result
);

    logic      push_valid, push_ready;
    tick_req_t push_req;
    logic      pop_valid, pop;
    tick_req_t pop_req;
    result_t   res;

    i2cm_front u_front (
        .tick       (tick),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_req    (pop_req)
    );

    i2cm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (pop_valid),
        .req       (pop_req),
        .pop       (pop),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (res)
    );

    assign result.scl_level = res.scl_level;
    assign result.sda_level = res.sda_level;
    assign result.sda_drive = res.sda_drive;
    assign result.busy_res  = res.busy_res;
    assign result.done_res  = res.done_res;
    assign result.read_data = res.read_data;
    assign result.ack_seen  = res.ack_seen;

endmodule
